>>> design/rbch_pkg.sv
// Package for the ray/box closest-hit block: register map, controller states,
// the controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package rbch_pkg;

  localparam int unsigned NUM_REGS   = 7;
  localparam int unsigned ADDR_WIDTH = 5;
  localparam int unsigned STEP_COUNT = 32;

  // Register indexes.
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;
  localparam logic [2:0] REG_MAX_DIST = 3'd6;

  localparam logic [1:0] AXIS_LAST = 2'd2;
  localparam logic [31:0] NO_HIT_DIST = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AXIS,
    S_DIV_START,
    S_DIV_RUN,
    S_DIV_STORE,
    S_AXIS_UPDATE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic signed [2:0][31:0] origin;
    logic signed [2:0][31:0] dir;
    logic        [30:0]      max_distance;
  } cfg_t;

  typedef struct packed {
    logic       take;
    logic       load;
    logic       zero_check;
    logic       div_start;
    logic       div_step;
    logic       div_store;
    logic       axis_update;
    logic       finish;
    logic [1:0] axis;
    logic       bound_hi;
  } cmd_t;

  typedef struct packed {
    logic box_valid;
    logic dir_zero;
    logic out_free;
  } status_t;

endpackage

>>> design/rbch_box_if.sv
// Input channel carrying one box per transfer.
// Uses no package.
`timescale 1ns / 1ps

interface rbch_box_if;
  logic               valid;
  logic               ready;
  logic        [15:0] box_id;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_min_y;
  logic signed [31:0] box_min_z;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_max_y;
  logic signed [31:0] box_max_z;
  logic               last_box;

  modport source (output valid, box_id, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, last_box, input ready);
  modport sink (input valid, box_id, box_min_x, box_min_y, box_min_z,
                box_max_x, box_max_y, box_max_z, last_box, output ready);
endinterface

>>> design/rbch_hit_if.sv
// Output channel carrying one hit result per transfer.
// Uses no package.
`timescale 1ns / 1ps

interface rbch_hit_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [30:0] hit_distance;
  logic        query_done;
  logic        best_found;
  logic [15:0] best_id;
  logic [30:0] best_distance;

  modport source (output valid, hit, hit_distance, query_done, best_found, best_id,
                  best_distance, input ready);
  modport sink (input valid, hit, hit_distance, query_done, best_found, best_id,
                best_distance, output ready);
endinterface

>>> design/rbch_ctrl.sv
// Controller for the slab test: walks the axes, sequences the shared divider
// and hands results to the output register. Depends on rbch_pkg.
`timescale 1ns / 1ps

module rbch_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  rbch_pkg::status_t status,
  output rbch_pkg::cmd_t    cmd
);

  rbch_pkg::state_t state, state_next;
  logic [1:0] axis;
  logic       bound_hi;
  logic [4:0] count;

  always_comb begin
    state_next = state;
    case (state)
      rbch_pkg::S_IDLE: begin
        if (status.box_valid) state_next = rbch_pkg::S_AXIS;
      end
      rbch_pkg::S_AXIS: begin
        if (!status.dir_zero) state_next = rbch_pkg::S_DIV_START;
        else if (axis == rbch_pkg::AXIS_LAST) state_next = rbch_pkg::S_FINISH;
      end
      rbch_pkg::S_DIV_START: state_next = rbch_pkg::S_DIV_RUN;
      rbch_pkg::S_DIV_RUN: begin
        if (count == 5'(rbch_pkg::STEP_COUNT - 1)) state_next = rbch_pkg::S_DIV_STORE;
      end
      rbch_pkg::S_DIV_STORE: begin
        state_next = bound_hi ? rbch_pkg::S_AXIS_UPDATE : rbch_pkg::S_DIV_START;
      end
      rbch_pkg::S_AXIS_UPDATE: begin
        state_next = (axis == rbch_pkg::AXIS_LAST) ? rbch_pkg::S_FINISH : rbch_pkg::S_AXIS;
      end
      rbch_pkg::S_FINISH: begin
        if (status.out_free) state_next = rbch_pkg::S_IDLE;
      end
      default: state_next = rbch_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.axis        = axis;
    cmd.bound_hi    = bound_hi;
    cmd.take        = (state == rbch_pkg::S_IDLE);
    cmd.load        = (state == rbch_pkg::S_IDLE) && status.box_valid;
    cmd.zero_check  = (state == rbch_pkg::S_AXIS) && status.dir_zero;
    cmd.div_start   = (state == rbch_pkg::S_DIV_START);
    cmd.div_step    = (state == rbch_pkg::S_DIV_RUN);
    cmd.div_store   = (state == rbch_pkg::S_DIV_STORE);
    cmd.axis_update = (state == rbch_pkg::S_AXIS_UPDATE);
    cmd.finish      = (state == rbch_pkg::S_FINISH) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rbch_pkg::S_IDLE;
      axis     <= '0;
      bound_hi <= 1'b0;
      count    <= '0;
    end else begin
      state <= state_next;
      if (cmd.load) axis <= '0;
      else if ((cmd.zero_check && axis != rbch_pkg::AXIS_LAST) ||
               (cmd.axis_update && axis != rbch_pkg::AXIS_LAST)) axis <= axis + 2'd1;
      if (state == rbch_pkg::S_AXIS) bound_hi <= 1'b0;
      else if (cmd.div_store) bound_hi <= 1'b1;
      if (cmd.div_start) count <= '0;
      else if (cmd.div_step) count <= count + 5'd1;
    end
  end

endmodule

>>> design/rbch_datapath.sv
// Datapath: captured box, one shared restoring divider for the slab
// distances, the hit interval, the nearest-hit tracker and the output register.
// Depends on rbch_pkg, rbch_box_if and rbch_hit_if.
`timescale 1ns / 1ps

module rbch_datapath (
  input  logic              clk,
  input  logic              rst,
  input  rbch_pkg::cfg_t    cfg,
  input  rbch_pkg::cmd_t    cmd,
  output rbch_pkg::status_t status,
  rbch_box_if.sink          box,
  rbch_hit_if.source        result
);

  logic signed [2:0][31:0] lo;
  logic signed [2:0][31:0] hi;
  logic        [15:0]      id;
  logic                    last;

  logic signed [31:0] tmin, tmax, t1, t2;
  logic               hit_flag;

  logic [31:0] rem, dl, quo, divisor;
  logic        neg, sat;

  logic [31:0] nearest_distance;
  logic [15:0] nearest_id;
  logic        out_valid;

  // Divider setup for the selected axis and bound.
  logic signed [31:0] org_sel, dir_sel, bound_sel;
  logic signed [32:0] num;
  logic        [32:0] num_mag;
  logic        [31:0] dir_mag;

  always_comb begin
    org_sel   = cfg.origin[cmd.axis];
    dir_sel   = cfg.dir[cmd.axis];
    bound_sel = cmd.bound_hi ? hi[cmd.axis] : lo[cmd.axis];
    num       = {bound_sel[31], bound_sel} - {org_sel[31], org_sel};
    num_mag   = num[32] ? 33'(-num) : 33'(num);
    dir_mag   = dir_sel[31] ? 32'(-dir_sel) : 32'(dir_sel);
  end

  // One quotient bit per step.
  logic [32:0] rs;
  logic        fits;
  always_comb begin
    rs   = {rem, dl[31]};
    fits = rs >= {1'b0, divisor};
  end

  // Saturated signed distance from the finished quotient.
  logic signed [31:0] t_div;
  always_comb begin
    if (sat || quo[31]) t_div = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else t_div = neg ? 32'(-quo) : 32'(quo);
  end

  // Interval update for one axis.
  logic signed [31:0] t_near, t_far, nmin, nmax;
  always_comb begin
    t_near = (t1 > t2) ? t2 : t1;
    t_far  = (t1 > t2) ? t1 : t2;
    nmin   = (t_near > tmin) ? t_near : tmin;
    nmax   = (t_far < tmax) ? t_far : tmax;
  end

  // Final decision and tracker update.
  logic        hit_final, take_new, found;
  logic [31:0] near_new;
  logic [15:0] id_new;
  always_comb begin
    hit_final = hit_flag && !tmin[31] && (tmin[30:0] <= cfg.max_distance);
    take_new  = hit_final && ({1'b0, tmin[30:0]} < nearest_distance);
    near_new  = take_new ? {1'b0, tmin[30:0]} : nearest_distance;
    id_new    = take_new ? id : nearest_id;
    found     = near_new != rbch_pkg::NO_HIT_DIST;
  end

  assign box.ready         = cmd.take;
  assign status.box_valid  = box.valid;
  assign status.dir_zero   = (dir_sel == '0);
  assign status.out_free   = !out_valid || result.ready;
  assign result.valid      = out_valid;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo   <= {box.box_min_z, box.box_min_y, box.box_min_x};
      hi   <= {box.box_max_z, box.box_max_y, box.box_max_x};
      id   <= box.box_id;
      last <= box.last_box;
      tmin <= '0;
      tmax <= {1'b0, cfg.max_distance};
      hit_flag <= 1'b1;
    end
    if (cmd.zero_check && (org_sel < $signed(lo[cmd.axis]) ||
                           org_sel > $signed(hi[cmd.axis]))) begin
      hit_flag <= 1'b0;
    end
    if (cmd.div_start) begin
      divisor <= dir_mag;
      neg     <= num[32] ^ dir_sel[31];
      sat     <= {15'd0, num_mag} >= {dir_mag, 16'd0};
      rem     <= {15'd0, num_mag[32:16]};
      dl      <= {num_mag[15:0], 16'd0};
      quo     <= '0;
    end
    if (cmd.div_step) begin
      rem <= fits ? 32'(rs - {1'b0, divisor}) : rs[31:0];
      dl  <= {dl[30:0], 1'b0};
      quo <= {quo[30:0], fits};
    end
    if (cmd.div_store) begin
      if (cmd.bound_hi) t2 <= t_div;
      else t1 <= t_div;
    end
    if (cmd.axis_update) begin
      tmin <= nmin;
      tmax <= nmax;
      if (nmin > nmax) hit_flag <= 1'b0;
    end
    if (cmd.finish) begin
      result.hit           <= hit_final;
      result.hit_distance  <= hit_final ? tmin[30:0] : '0;
      result.query_done    <= last;
      result.best_found    <= found;
      result.best_id       <= found ? id_new : '0;
      result.best_distance <= found ? near_new[30:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      nearest_distance <= rbch_pkg::NO_HIT_DIST;
      nearest_id       <= '0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (last) begin
          nearest_distance <= rbch_pkg::NO_HIT_DIST;
          nearest_id       <= '0;
        end else begin
          nearest_distance <= near_new;
          nearest_id       <= id_new;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/ray_box_closest_hit.sv
// Top level of the ray/box closest-hit block: configuration registers,
// controller and datapath. Depends on rbch_pkg, the channel interfaces,
// rbch_ctrl and rbch_datapath.
`timescale 1ns / 1ps

// One ray is written through the register port (origin, direction, largest
// distance, Q16.16). Boxes then arrive one per transfer; each yields one
// result with its own hit flag and entry distance plus the nearest hit of the
// query so far, the earlier box winning a tie. The box marked last_box closes
// the query and clears the tracker. Boxes are handled one at a time, and a
// finished box waits for the previous result to leave the output register.
// One shared restoring divider produces each of the two slab distances of an
// axis at one quotient bit per cycle; an axis whose direction is zero skips
// the divider. The next box is taken while a finished result still waits in
// the output register.

module ray_box_closest_hit (
  input  logic                              clk,
  input  logic                              rst,
  rbch_box_if.sink                          box,
  rbch_hit_if.source                        result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rbch_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  rbch_pkg::cfg_t    cfg;
  rbch_pkg::cmd_t    cmd;
  rbch_pkg::status_t status;

  logic [2:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_index)
        rbch_pkg::REG_ORIGIN_X: cfg.origin[0] <= pwdata;
        rbch_pkg::REG_ORIGIN_Y: cfg.origin[1] <= pwdata;
        rbch_pkg::REG_ORIGIN_Z: cfg.origin[2] <= pwdata;
        rbch_pkg::REG_DIR_X:    cfg.dir[0]    <= pwdata;
        rbch_pkg::REG_DIR_Y:    cfg.dir[1]    <= pwdata;
        rbch_pkg::REG_DIR_Z:    cfg.dir[2]    <= pwdata;
        rbch_pkg::REG_MAX_DIST: cfg.max_distance <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      rbch_pkg::REG_ORIGIN_X: prdata = cfg.origin[0];
      rbch_pkg::REG_ORIGIN_Y: prdata = cfg.origin[1];
      rbch_pkg::REG_ORIGIN_Z: prdata = cfg.origin[2];
      rbch_pkg::REG_DIR_X:    prdata = cfg.dir[0];
      rbch_pkg::REG_DIR_Y:    prdata = cfg.dir[1];
      rbch_pkg::REG_DIR_Z:    prdata = cfg.dir[2];
      rbch_pkg::REG_MAX_DIST: prdata = {1'b0, cfg.max_distance};
      default:                prdata = '0;
    endcase
  end

  rbch_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  rbch_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status),
    .box    (box),
    .result (result)
  );

  // A box is worked on alone, so the channel closes right after a transfer.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (box.valid && box.ready) |=> !box.ready)
    else $error("box channel still open after a transfer");

  // The nearest hit can never be farther than the box that was just hit.
  a_best_covers_hit: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.hit) |->
      (result.best_found && result.best_distance <= result.hit_distance))
    else $error("nearest hit farther than current hit");

  a_empty_best: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.best_found) |->
      (result.best_id == '0 && result.best_distance == '0 && !result.hit))
    else $error("no nearest hit but fields not cleared");

endmodule
